### hw/rtl/adbs_pkg.sv
// ----------------------------------------------------------------------------
// adbs_pkg
// Shared types and constants of the DMA burst sequencer: event and action
// codes, field widths and the item and result records.
// ----------------------------------------------------------------------------
`default_nettype none

package adbs_pkg;

	localparam int MAX_BURST = 16;
	localparam int LEN_BITS  = 20;
	localparam int ADDR_W    = 32;
	localparam int WORD_W    = 32;
	localparam int KIND_W    = 3;
	localparam int LEN_CODE_W = 4;
	localparam int BEAT_W    = $clog2(MAX_BURST + 1);
	localparam int NUM_KINDS = 1 << KIND_W;

	typedef enum logic [KIND_W-1:0] {
		KIND_CMD      = 3'd0,
		KIND_ADDR_ACK = 3'd1,
		KIND_RD_BEAT  = 3'd2,
		KIND_RD_TAKEN = 3'd3,
		KIND_WR_GIVEN = 3'd4,
		KIND_WR_ACK   = 3'd5,
		KIND_WR_RESP  = 3'd6,
		KIND_UNUSED   = 3'd7
	} kind_t;

	typedef enum logic [3:0] {
		ACT_IGNORED    = 4'd0,
		ACT_RD_ADDR    = 4'd1,
		ACT_RD_TAKE    = 4'd2,
		ACT_RD_DELIVER = 4'd3,
		ACT_WR_ADDR    = 4'd4,
		ACT_WR_REQ     = 4'd5,
		ACT_WR_SEND    = 4'd6,
		ACT_AWAIT      = 4'd7,
		ACT_DONE       = 4'd8
	} action_t;

	// Classified event as it waits between the front and the back.
	typedef struct packed {
		logic [NUM_KINDS-1:0] kind_oh;
		logic                 write_dir;
		logic [ADDR_W-1:0]    base_address;
		logic [LEN_BITS-1:0]  length_words;
		logic [WORD_W-1:0]    beat_word;
	} item_t;

	typedef struct packed {
		action_t               action;
		logic [ADDR_W-1:0]     burst_address;
		logic [LEN_CODE_W-1:0] burst_len_code;
		logic [WORD_W-1:0]     word_out;
		logic                  last_beat;
	} result_t;

endpackage

`default_nettype wire

### hw/rtl/adbs_front.sv
// ----------------------------------------------------------------------------
// adbs_front
// Accepts handshake events, decodes their kind to one-hot and holds them in a
// four-entry queue until the sequencer takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module adbs_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	output logic                                full,
	input  wire logic [adbs_pkg::KIND_W-1:0]    kind,
	input  wire logic                           write_dir,
	input  wire logic [adbs_pkg::ADDR_W-1:0]    base_address,
	input  wire logic [adbs_pkg::LEN_BITS-1:0]  length_words,
	input  wire logic [adbs_pkg::WORD_W-1:0]    beat_word,
	output logic                                q_valid,
	output adbs_pkg::item_t                     q_item,
	input  wire logic                           q_take
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	adbs_pkg::item_t       mem_q [DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [PTR_W:0]        count_q;
	adbs_pkg::item_t       in_item;
	logic                  wr_en;
	logic                  rd_en;

	always_comb begin
		in_item.kind_oh      = adbs_pkg::NUM_KINDS'(1) << kind;
		in_item.write_dir    = write_dir;
		in_item.base_address = base_address;
		in_item.length_words = length_words;
		in_item.beat_word    = beat_word;
	end

	assign full    = (count_q == (PTR_W+1)'(DEPTH));
	assign q_valid = (count_q != '0);
	assign q_item  = mem_q[rd_ptr_q];
	assign wr_en   = push && !full;
	assign rd_en   = q_take && q_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### hw/rtl/adbs_back.sv
// ----------------------------------------------------------------------------
// adbs_back
// Burst sequencer: takes one classified event per cycle while the result
// queue has room, advances the phase of the current command and places the
// resulting action in a two-entry result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module adbs_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_valid,
	input  wire adbs_pkg::item_t    q_item,
	output logic                    q_take,
	output logic                    empty,
	input  wire logic               pop,
	output adbs_pkg::result_t       head
);

	typedef enum logic [6:0] {
		PH_IDLE  = 7'b0000001,
		PH_ADDR  = 7'b0000010,
		PH_RBEAT = 7'b0000100,
		PH_RCONS = 7'b0001000,
		PH_WPROD = 7'b0010000,
		PH_WBEAT = 7'b0100000,
		PH_WRESP = 7'b1000000
	} phase_t;

	typedef struct packed {
		adbs_pkg::result_t             res;
		logic [adbs_pkg::BEAT_W-1:0]   beats;
	} burst_t;

	phase_t                              phase_q, phase_d;
	logic                                dir_q, dir_d;
	logic [adbs_pkg::ADDR_W-1:0]         start_q, start_d;
	logic [adbs_pkg::LEN_BITS-1:0]       done_q, done_d;
	logic [adbs_pkg::LEN_BITS-1:0]       left_q, left_d;
	logic [adbs_pkg::BEAT_W-1:0]         beats_q, beats_d;
	logic [adbs_pkg::BEAT_W-1:0]         idx_q, idx_d;

	logic [adbs_pkg::BEAT_W-1:0]         idx_inc;
	logic [adbs_pkg::LEN_BITS-1:0]       done_inc;
	logic [adbs_pkg::LEN_BITS-1:0]       left_dec;
	logic                                burst_end;
	burst_t                              ob_cur, ob_cnt, ob_cmd;
	adbs_pkg::result_t                   res;

	adbs_pkg::result_t                   out_q [2];
	logic                                out_wr_q;
	logic                                out_rd_q;
	logic [1:0]                          out_cnt_q;
	logic                                out_pop;

	function automatic burst_t open_burst(
		input logic                          dir,
		input logic [adbs_pkg::ADDR_W-1:0]   start,
		input logic [adbs_pkg::LEN_BITS-1:0] done,
		input logic [adbs_pkg::LEN_BITS-1:0] left
	);
		burst_t b;
		b = '0;
		if (left > adbs_pkg::LEN_BITS'(adbs_pkg::MAX_BURST)) begin
			b.beats = adbs_pkg::BEAT_W'(adbs_pkg::MAX_BURST);
		end else begin
			b.beats = left[adbs_pkg::BEAT_W-1:0];
		end
		b.res.action         = dir ? adbs_pkg::ACT_WR_ADDR : adbs_pkg::ACT_RD_ADDR;
		b.res.burst_address  = start + adbs_pkg::ADDR_W'({done, 2'b00});
		b.res.burst_len_code = adbs_pkg::LEN_CODE_W'(b.beats - 1'b1);
		return b;
	endfunction

	assign idx_inc   = idx_q + 1'b1;
	assign done_inc  = done_q + 1'b1;
	assign left_dec  = left_q - 1'b1;
	assign burst_end = (idx_inc >= beats_q);

	// Candidate bursts: the next one after the current counts, after
	// counting one more word, and the first one of a new command.
	assign ob_cur = open_burst(dir_q, start_q, done_q, left_q);
	assign ob_cnt = open_burst(dir_q, start_q, done_inc, left_dec);
	assign ob_cmd = open_burst(q_item.write_dir, q_item.base_address, '0,
		q_item.length_words);

	always_comb begin
		phase_d = phase_q;
		dir_d   = dir_q;
		start_d = start_q;
		done_d  = done_q;
		left_d  = left_q;
		beats_d = beats_q;
		idx_d   = idx_q;
		res     = '0;
		res.action = adbs_pkg::ACT_IGNORED;
		case (phase_q)
			PH_IDLE: begin
				if (q_item.kind_oh[adbs_pkg::KIND_CMD]) begin
					dir_d   = q_item.write_dir;
					start_d = q_item.base_address;
					left_d  = q_item.length_words;
					done_d  = '0;
					idx_d   = '0;
					beats_d = '0;
					if (q_item.length_words == '0) begin
						res.action = adbs_pkg::ACT_DONE;
					end else begin
						res     = ob_cmd.res;
						beats_d = ob_cmd.beats;
						phase_d = PH_ADDR;
					end
				end
			end
			PH_ADDR: begin
				if (q_item.kind_oh[adbs_pkg::KIND_ADDR_ACK]) begin
					if (dir_q) begin
						phase_d    = PH_WPROD;
						res.action = adbs_pkg::ACT_WR_REQ;
					end else begin
						phase_d    = PH_RBEAT;
						res.action = adbs_pkg::ACT_RD_TAKE;
					end
				end
			end
			PH_RBEAT: begin
				if (q_item.kind_oh[adbs_pkg::KIND_RD_BEAT]) begin
					phase_d      = PH_RCONS;
					res.action   = adbs_pkg::ACT_RD_DELIVER;
					res.word_out = q_item.beat_word;
				end
			end
			PH_RCONS: begin
				if (q_item.kind_oh[adbs_pkg::KIND_RD_TAKEN]) begin
					idx_d  = idx_inc;
					done_d = done_inc;
					left_d = left_dec;
					if (!burst_end) begin
						phase_d    = PH_RBEAT;
						res.action = adbs_pkg::ACT_RD_TAKE;
					end else if (left_dec != '0) begin
						res     = ob_cnt.res;
						beats_d = ob_cnt.beats;
						idx_d   = '0;
						phase_d = PH_ADDR;
					end else begin
						res.action = adbs_pkg::ACT_DONE;
						phase_d    = PH_IDLE;
					end
				end
			end
			PH_WPROD: begin
				if (q_item.kind_oh[adbs_pkg::KIND_WR_GIVEN]) begin
					phase_d       = PH_WBEAT;
					res.action    = adbs_pkg::ACT_WR_SEND;
					res.word_out  = q_item.beat_word;
					res.last_beat = burst_end;
				end
			end
			PH_WBEAT: begin
				if (q_item.kind_oh[adbs_pkg::KIND_WR_ACK]) begin
					idx_d  = idx_inc;
					done_d = done_inc;
					left_d = left_dec;
					if (!burst_end) begin
						phase_d    = PH_WPROD;
						res.action = adbs_pkg::ACT_WR_REQ;
					end else begin
						phase_d    = PH_WRESP;
						res.action = adbs_pkg::ACT_AWAIT;
					end
				end
			end
			PH_WRESP: begin
				if (q_item.kind_oh[adbs_pkg::KIND_WR_RESP]) begin
					if (left_q != '0) begin
						res     = ob_cur.res;
						beats_d = ob_cur.beats;
						idx_d   = '0;
						phase_d = PH_ADDR;
					end else begin
						res.action = adbs_pkg::ACT_DONE;
						phase_d    = PH_IDLE;
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	// One event a cycle as long as the result queue has room.
	assign q_take  = q_valid && (out_cnt_q != 2'd2);
	assign empty   = (out_cnt_q == 2'd0);
	assign out_pop = pop && !empty;
	assign head    = out_q[out_rd_q];

	always_ff @(posedge clk) begin
		if (q_take) begin
			out_q[out_wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			dir_q     <= 1'b0;
			start_q   <= '0;
			done_q    <= '0;
			left_q    <= '0;
			beats_q   <= '0;
			idx_q     <= '0;
			out_wr_q  <= 1'b0;
			out_rd_q  <= 1'b0;
			out_cnt_q <= 2'd0;
		end else begin
			if (q_take) begin
				phase_q  <= phase_d;
				dir_q    <= dir_d;
				start_q  <= start_d;
				done_q   <= done_d;
				left_q   <= left_d;
				beats_q  <= beats_d;
				idx_q    <= idx_d;
				out_wr_q <= ~out_wr_q;
			end
			if (out_pop) begin
				out_rd_q <= ~out_rd_q;
			end
			case ({q_take, out_pop})
				2'b10:   out_cnt_q <= out_cnt_q + 1'b1;
				2'b01:   out_cnt_q <= out_cnt_q - 1'b1;
				default: out_cnt_q <= out_cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### hw/rtl/axi_dma_burst_sequencer.sv
// ----------------------------------------------------------------------------
// axi_dma_burst_sequencer
// Splits DMA commands into incrementing bursts of up to 16 beats and answers
// every bus handshake event with exactly one action.
//
// Input channel: push/full. Each beat is one event: a command (direction,
// base address, length in words) or a handshake notice from the bus, the
// read consumer or the write producer. Events are held in a four-entry queue.
// Result channel: empty/pop. The oldest action sits on the result ports while
// empty is low; a two-entry queue holds finished actions.
// Throughput is one event per cycle while the result queue has room, set by
// the sequencer, which updates the phase and computes a burst address for
// each event it takes. An accepted event waits in the input queue until the
// sequencer takes it and registers its action into the result queue.
// When the receiver stops popping, the result queue fills, the sequencer
// holds, and the input queue raises full once its four entries are taken.
// Reset clears both queues and returns the sequencer to idle with no
// command in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module axi_dma_burst_sequencer (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                push,
	output logic                                     full,
	input  wire logic [adbs_pkg::KIND_W-1:0]         kind,
	input  wire logic                                write_dir,
	input  wire logic [adbs_pkg::ADDR_W-1:0]         base_address,
	input  wire logic [adbs_pkg::LEN_BITS-1:0]       length_words,
	input  wire logic [adbs_pkg::WORD_W-1:0]         beat_word,
	output logic                                     empty,
	input  wire logic                                pop,
	output logic [3:0]                               action,
	output logic [adbs_pkg::ADDR_W-1:0]              burst_address,
	output logic [adbs_pkg::LEN_CODE_W-1:0]          burst_len_code,
	output logic [adbs_pkg::WORD_W-1:0]              word_out,
	output logic                                     last_beat
);

	logic               q_valid;
	logic               q_take;
	adbs_pkg::item_t    q_item;
	adbs_pkg::result_t  head;

	adbs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.kind         (kind),
		.write_dir    (write_dir),
		.base_address (base_address),
		.length_words (length_words),
		.beat_word    (beat_word),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_take       (q_take)
	);

	adbs_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_take  (q_take),
		.empty   (empty),
		.pop     (pop),
		.head    (head)
	);

	assign action         = head.action;
	assign burst_address  = head.burst_address;
	assign burst_len_code = head.burst_len_code;
	assign word_out       = head.word_out;
	assign last_beat      = head.last_beat;

endmodule

`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for axi_dma_burst_sequencer. A handful of directed event streams
// cover the zero-length command, out-of-phase events and single-burst read
// and write transfers. Random streams of mostly well-formed handshake
// sequences follow, under several patterns of sender gaps and receiver
// stalls, a long receiver hold-off that fills the block, and sender pauses
// until the block has drained. Every action is checked field by field
// against an in-order prediction of the sequencer.
// ----------------------------------------------------------------------------

module tb;

	localparam int CYCLE_LIMIT = 400000;

	typedef enum logic [6:0] {
		PH_IDLE  = 7'b0000001,
		PH_ADDR  = 7'b0000010,
		PH_RBEAT = 7'b0000100,
		PH_RCONS = 7'b0001000,
		PH_WPROD = 7'b0010000,
		PH_WBEAT = 7'b0100000,
		PH_WRESP = 7'b1000000
	} seq_phase_t;

	logic                              clk;
	logic                              arst_n = 1'b0;
	logic                              push = 1'b0;
	logic                              full;
	adbs_pkg::kind_t                   kind = adbs_pkg::KIND_CMD;
	logic                              write_dir = 1'b0;
	logic [adbs_pkg::ADDR_W-1:0]       base_address = '0;
	logic [adbs_pkg::LEN_BITS-1:0]     length_words = '0;
	logic [adbs_pkg::WORD_W-1:0]       beat_word = '0;
	logic                              empty;
	logic                              pop = 1'b0;
	logic [3:0]                        action;
	logic [adbs_pkg::ADDR_W-1:0]       burst_address;
	logic [adbs_pkg::LEN_CODE_W-1:0]   burst_len_code;
	logic [adbs_pkg::WORD_W-1:0]       word_out;
	logic                              last_beat;

	// Predicted sequencer state.
	seq_phase_t                        seq_phase = PH_IDLE;
	logic                              seq_write = 1'b0;
	logic [adbs_pkg::ADDR_W-1:0]       seq_base = '0;
	logic [adbs_pkg::LEN_BITS-1:0]     seq_moved = '0;
	logic [adbs_pkg::LEN_BITS-1:0]     seq_left = '0;
	logic [adbs_pkg::BEAT_W-1:0]       seq_burst_beats = '0;
	logic [adbs_pkg::BEAT_W-1:0]       seq_beat_idx = '0;

	adbs_pkg::result_t expected_actions[$];
	adbs_pkg::result_t want;
	int      mismatch_count = 0;
	int      cycle_count = 0;
	int      tx_gap_pct = 0;
	int      rx_stall_pct = 0;
	logic    rx_hold = 1'b0;

	axi_dma_burst_sequencer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.kind(kind),
		.write_dir(write_dir),
		.base_address(base_address),
		.length_words(length_words),
		.beat_word(beat_word),
		.empty(empty),
		.pop(pop),
		.action(action),
		.burst_address(burst_address),
		.burst_len_code(burst_len_code),
		.word_out(word_out),
		.last_beat(last_beat)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("axi_dma_burst_sequencer test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || rx_hold)
			pop <= 1'b0;
		else
			pop <= ($urandom_range(99) >= rx_stall_pct);
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	function automatic adbs_pkg::result_t open_burst();
		adbs_pkg::result_t r;
		logic [adbs_pkg::BEAT_W-1:0] beats;
		r = '0;
		beats = (seq_left > adbs_pkg::MAX_BURST) ? adbs_pkg::BEAT_W'(adbs_pkg::MAX_BURST) :
			adbs_pkg::BEAT_W'(seq_left);
		seq_burst_beats = beats;
		seq_beat_idx = '0;
		seq_phase = PH_ADDR;
		r.action = seq_write ? adbs_pkg::ACT_WR_ADDR : adbs_pkg::ACT_RD_ADDR;
		r.burst_address = seq_base + (adbs_pkg::ADDR_W'(seq_moved) << 2);
		r.burst_len_code = adbs_pkg::LEN_CODE_W'(beats - 1'b1);
		return r;
	endfunction

	// Returns high when the beat just counted closes the burst.
	function automatic logic count_beat();
		seq_beat_idx = seq_beat_idx + 1'b1;
		seq_moved = seq_moved + 1'b1;
		seq_left = seq_left - 1'b1;
		return seq_beat_idx >= seq_burst_beats;
	endfunction

	function automatic adbs_pkg::result_t next_burst_or_done();
		adbs_pkg::result_t r;
		r = '0;
		if (seq_left != '0) begin
			r = open_burst();
		end else begin
			seq_phase = PH_IDLE;
			r.action = adbs_pkg::ACT_DONE;
		end
		return r;
	endfunction

	function automatic adbs_pkg::result_t predict_action(adbs_pkg::kind_t k, logic wd,
			logic [adbs_pkg::ADDR_W-1:0] ba, logic [adbs_pkg::LEN_BITS-1:0] lw,
			logic [adbs_pkg::WORD_W-1:0] bw);
		adbs_pkg::result_t r;
		r = '0;
		r.action = adbs_pkg::ACT_IGNORED;
		case (seq_phase)
			PH_IDLE: if (k == adbs_pkg::KIND_CMD) begin
				seq_write = wd;
				seq_base = ba;
				seq_left = lw;
				seq_moved = '0;
				seq_beat_idx = '0;
				seq_burst_beats = '0;
				if (lw == '0)
					r.action = adbs_pkg::ACT_DONE;
				else
					r = open_burst();
			end
			PH_ADDR: if (k == adbs_pkg::KIND_ADDR_ACK) begin
				seq_phase = seq_write ? PH_WPROD : PH_RBEAT;
				r.action = seq_write ? adbs_pkg::ACT_WR_REQ : adbs_pkg::ACT_RD_TAKE;
			end
			PH_RBEAT: if (k == adbs_pkg::KIND_RD_BEAT) begin
				seq_phase = PH_RCONS;
				r.action = adbs_pkg::ACT_RD_DELIVER;
				r.word_out = bw;
			end
			PH_RCONS: if (k == adbs_pkg::KIND_RD_TAKEN) begin
				if (!count_beat()) begin
					seq_phase = PH_RBEAT;
					r.action = adbs_pkg::ACT_RD_TAKE;
				end else begin
					r = next_burst_or_done();
				end
			end
			PH_WPROD: if (k == adbs_pkg::KIND_WR_GIVEN) begin
				seq_phase = PH_WBEAT;
				r.action = adbs_pkg::ACT_WR_SEND;
				r.word_out = bw;
				r.last_beat = (int'(seq_beat_idx) + 1 >= int'(seq_burst_beats));
			end
			PH_WBEAT: if (k == adbs_pkg::KIND_WR_ACK) begin
				if (!count_beat()) begin
					seq_phase = PH_WPROD;
					r.action = adbs_pkg::ACT_WR_REQ;
				end else begin
					seq_phase = PH_WRESP;
					r.action = adbs_pkg::ACT_AWAIT;
				end
			end
			PH_WRESP: if (k == adbs_pkg::KIND_WR_RESP) begin
				r = next_burst_or_done();
			end
			default: seq_phase = PH_IDLE;
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
		$display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, exp_val);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_actions.size() == 0) begin
				report_mismatch("unexpected result, action", 32'(action),
					32'(adbs_pkg::ACT_IGNORED));
			end else begin
				want = expected_actions.pop_front();
				if (action !== want.action)
					report_mismatch("action", 32'(action), 32'(want.action));
				if (burst_address !== want.burst_address)
					report_mismatch("burst_address", burst_address, want.burst_address);
				if (burst_len_code !== want.burst_len_code)
					report_mismatch("burst_len_code", 32'(burst_len_code),
						32'(want.burst_len_code));
				if (word_out !== want.word_out)
					report_mismatch("word_out", word_out, want.word_out);
				if (last_beat !== want.last_beat)
					report_mismatch("last_beat", 32'(last_beat), 32'(want.last_beat));
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	// Offers one event and returns once the block has taken it. Push stays high
	// afterwards so that back-to-back events follow without a gap.
	task automatic send_event(input adbs_pkg::kind_t k, input logic wd,
			input logic [adbs_pkg::ADDR_W-1:0] ba, input logic [adbs_pkg::LEN_BITS-1:0] lw,
			input logic [adbs_pkg::WORD_W-1:0] bw, output adbs_pkg::action_t act);
		adbs_pkg::result_t r;
		if ($urandom_range(99) < tx_gap_pct) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		push <= 1'b1;
		kind <= k;
		write_dir <= wd;
		base_address <= ba;
		length_words <= lw;
		beat_word <= bw;
		@(posedge clk);
		while (full) @(posedge clk);
		r = predict_action(k, wd, ba, lw, bw);
		expected_actions.push_back(r);
		act = r.action;
	endtask

	task automatic wait_for_drain();
		push <= 1'b0;
		@(posedge clk);
		while (expected_actions.size() != 0) @(posedge clk);
	endtask

	// Sends the event that the current phase waits for, with random content, or
	// now and then a fully random event. Command lengths are kept short so that
	// new commands keep coming.
	task automatic send_next(output adbs_pkg::action_t act);
		adbs_pkg::kind_t               k;
		logic [adbs_pkg::ADDR_W-1:0]   ba;
		logic [adbs_pkg::LEN_BITS-1:0] lw;
		ba = $urandom;
		lw = adbs_pkg::LEN_BITS'($urandom);
		if ($urandom_range(99) < 12) begin
			k = adbs_pkg::kind_t'($urandom_range(7));
		end else begin
			case (seq_phase)
				PH_IDLE:  k = adbs_pkg::KIND_CMD;
				PH_ADDR:  k = adbs_pkg::KIND_ADDR_ACK;
				PH_RBEAT: k = adbs_pkg::KIND_RD_BEAT;
				PH_RCONS: k = adbs_pkg::KIND_RD_TAKEN;
				PH_WPROD: k = adbs_pkg::KIND_WR_GIVEN;
				PH_WBEAT: k = adbs_pkg::KIND_WR_ACK;
				default:  k = adbs_pkg::KIND_WR_RESP;
			endcase
		end
		if (k == adbs_pkg::KIND_CMD) begin
			case ($urandom_range(3))
				0: ba = ba & ~32'h3;
				1: ba = 32'hFFFF_FFC0 | (ba & 32'h3C);
				default: ;
			endcase
			case ($urandom_range(9))
				0: lw = '0;
				1: lw = adbs_pkg::LEN_BITS'($urandom_range(1, 4) * adbs_pkg::MAX_BURST);
				2: lw = adbs_pkg::LEN_BITS'($urandom_range(33, 70));
				default: lw = adbs_pkg::LEN_BITS'($urandom_range(1, 20));
			endcase
		end
		send_event(k, 1'($urandom), ba, lw, $urandom, act);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	task automatic test_idle_events();
		adbs_pkg::action_t act;
		send_event(adbs_pkg::KIND_ADDR_ACK, 1'b1, '1, '1, '1, act);
		send_event(adbs_pkg::KIND_RD_BEAT, 1'b0, '0, '0, '0, act);
		send_event(adbs_pkg::KIND_RD_TAKEN, 1'b1, '1, '1, '1, act);
		send_event(adbs_pkg::KIND_WR_GIVEN, 1'b0, '0, '0, '0, act);
		send_event(adbs_pkg::KIND_WR_ACK, 1'b1, '1, '1, '1, act);
		send_event(adbs_pkg::KIND_WR_RESP, 1'b0, '0, '0, '0, act);
		send_event(adbs_pkg::KIND_UNUSED, 1'b1, '1, '1, '1, act);
	endtask

	task automatic test_zero_length();
		adbs_pkg::action_t act;
		send_event(adbs_pkg::KIND_CMD, 1'b1, '1, '0, '1, act);
		send_event(adbs_pkg::KIND_CMD, 1'b0, '0, '0, '0, act);
	endtask

	// One read beat at the top of the address space, with a command arriving
	// while busy that must be ignored.
	task automatic test_single_read();
		adbs_pkg::action_t act;
		send_event(adbs_pkg::KIND_CMD, 1'b0, 32'hFFFF_FFFC, adbs_pkg::LEN_BITS'(1), '0, act);
		send_event(adbs_pkg::KIND_CMD, 1'b1, '1, '1, '1, act);
		send_event(adbs_pkg::KIND_ADDR_ACK, 1'b0, '0, '0, '0, act);
		send_event(adbs_pkg::KIND_RD_BEAT, 1'b0, '0, '0, '1, act);
		send_event(adbs_pkg::KIND_RD_TAKEN, 1'b0, '0, '0, '0, act);
	endtask

	task automatic test_two_beat_write();
		adbs_pkg::action_t act;
		send_event(adbs_pkg::KIND_CMD, 1'b1, '0, adbs_pkg::LEN_BITS'(2), '0, act);
		send_event(adbs_pkg::KIND_ADDR_ACK, 1'b0, '0, '0, '0, act);
		send_event(adbs_pkg::KIND_WR_GIVEN, 1'b0, '0, '0, '0, act);
		send_event(adbs_pkg::KIND_WR_ACK, 1'b0, '0, '0, '0, act);
		send_event(adbs_pkg::KIND_WR_GIVEN, 1'b0, '0, '0, 32'hA5A5_5A5A, act);
		send_event(adbs_pkg::KIND_WR_RESP, 1'b0, '0, '0, '0, act);
		send_event(adbs_pkg::KIND_WR_ACK, 1'b0, '0, '0, '0, act);
		send_event(adbs_pkg::KIND_WR_RESP, 1'b0, '0, '0, '0, act);
	endtask

	task automatic test_random_traffic(int gap_pct, int stall_pct, int n_events);
		adbs_pkg::action_t act;
		tx_gap_pct = gap_pct;
		rx_stall_pct <= stall_pct;
		repeat (n_events) send_next(act);
	endtask

	// The receiver stops popping long enough for both queues to fill, so full
	// rises while the sender keeps offering beats.
	task automatic test_receiver_holdoff();
		adbs_pkg::action_t act;
		tx_gap_pct = 0;
		fork
			begin
				rx_hold <= 1'b1;
				repeat (250) @(posedge clk);
				rx_hold <= 1'b0;
			end
		join_none
		repeat (40) send_next(act);
	endtask

	task automatic test_sender_pause();
		adbs_pkg::action_t act;
		tx_gap_pct = 10;
		rx_stall_pct <= 30;
		repeat (6) begin
			repeat ($urandom_range(3, 15)) send_next(act);
			wait_for_drain();
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_events();
		test_zero_length();
		test_single_read();
		test_two_beat_write();
		test_random_traffic(0, 0, 380);
		test_random_traffic(48, 0, 380);
		test_random_traffic(0, 48, 380);
		test_random_traffic(10, 10, 380);
		test_receiver_holdoff();
		test_sender_pause();
		wait_for_drain();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("axi_dma_burst_sequencer test passed");
		else
			$display("axi_dma_burst_sequencer test failed");
		$finish;
	end

endmodule

### files.f
hw/rtl/adbs_pkg.sv
hw/rtl/adbs_front.sv
hw/rtl/adbs_back.sv
hw/rtl/axi_dma_burst_sequencer.sv
verif/tb.sv
